// ===== rtl/core/byte_code_cpu_step_macros.svh =====
// Assertion macros for the byte-code core RTL, used by the back end.
`ifndef BYTE_CODE_CPU_STEP_MACROS_SVH
`define BYTE_CODE_CPU_STEP_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define BCCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition that must never be true outside reset.
`define BCCS_ASSERT_NEVER(label, cond, msg) \
  `BCCS_ASSERT(label, !(cond), msg)

`endif

// ===== rtl/core/bccs_pkg.sv =====
// Package with the types, constants and opcodes of the byte-code core.
`timescale 1ns / 1ps
package bccs_pkg;

  // Local memory size in bytes; must be a power of two.
  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned MEM_AW    = $clog2(MEM_BYTES);

  // Depth of the request queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  // Input kinds as they arrive on the request channel.
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_EXEC  = 2'd2;

  // Opcodes.
  localparam logic [7:0] OPC_STOP  = 8'h00;
  localparam logic [7:0] OPC_LDB   = 8'h01;
  localparam logic [7:0] OPC_LDW   = 8'h02;
  localparam logic [7:0] OPC_MVDA1 = 8'h03;
  localparam logic [7:0] OPC_STA1  = 8'h04;
  localparam logic [7:0] OPC_MVA1D = 8'h05;
  localparam logic [7:0] OPC_MVD2D = 8'h06;
  localparam logic [7:0] OPC_MVDD2 = 8'h07;
  localparam logic [7:0] OPC_MVDA2 = 8'h08;
  localparam logic [7:0] OPC_INC   = 8'h09;
  localparam logic [7:0] OPC_DEC   = 8'h0A;
  localparam logic [7:0] OPC_JMP   = 8'h0B;
  localparam logic [7:0] OPC_JZ    = 8'h0C;
  localparam logic [7:0] OPC_JNZ   = 8'h0D;
  localparam logic [7:0] OPC_STA2  = 8'h0E;
  localparam logic [7:0] OPC_LDA1  = 8'h0F;
  localparam logic [7:0] OPC_LDA2  = 8'h10;
  localparam logic [7:0] OPC_TST   = 8'h11;
  localparam logic [7:0] OPC_TSTB  = 8'h12;
  localparam logic [7:0] OPC_MVA2D = 8'h13;
  localparam logic [7:0] OPC_NOP   = 8'hFF;

  localparam logic [15:0] HI_MASK = 16'hFF00;

  // Classified request operation.
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_EXEC  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [MEM_AW-1:0] addr;
    logic [7:0]        wdata;
  } req_t;

  // Status from the back end to the front end.
  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_RD     = 7'b0000100,
    ST_OPC    = 7'b0001000,
    ST_IMM_LO = 7'b0010000,
    ST_IMM_HI = 7'b0100000,
    ST_DATA   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic [15:0] instr_pointer;
    logic [15:0] data_reg_one;
    logic [15:0] data_reg_two;
    logic [15:0] addr_reg_one;
    logic [15:0] addr_reg_two;
    logic [7:0]  last_opcode;
    logic        zero_flag;
    logic        halted;
    logic        bad_opcode;
  } rsp_t;

endpackage

// ===== rtl/core/bccs_if.sv =====
// Request and response channel interfaces of the byte-code core.
`timescale 1ns / 1ps
interface bccs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] address;
  logic [7:0]  write_byte;

  modport source (output valid, kind, address, write_byte, input ready);
  modport sink   (input valid, kind, address, write_byte, output ready);
endinterface

interface bccs_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_byte;
  logic [15:0] instr_pointer;
  logic [15:0] data_reg_one;
  logic [15:0] data_reg_two;
  logic [15:0] addr_reg_one;
  logic [15:0] addr_reg_two;
  logic [7:0]  last_opcode;
  logic        zero_flag;
  logic        halted;
  logic        bad_opcode;

  modport source (
    output valid, read_byte, instr_pointer, data_reg_one, data_reg_two,
           addr_reg_one, addr_reg_two, last_opcode, zero_flag, halted, bad_opcode,
    input  ready
  );
  modport sink (
    input  valid, read_byte, instr_pointer, data_reg_one, data_reg_two,
           addr_reg_one, addr_reg_two, last_opcode, zero_flag, halted, bad_opcode,
    output ready
  );
endinterface

// ===== rtl/core/bccs_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module bccs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bccs_front.sv =====
// Front end: accepts requests, classifies them and hands them to the queue.
`timescale 1ns / 1ps
module bccs_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bccs_in_if.sink               req_i,
  input  bccs_pkg::back_status_t status_i,
  output logic                  push_valid_o,
  output bccs_pkg::req_t        push_req_o,
  input  logic                  push_ready_i
);

  logic           valid_q, valid_d;
  bccs_pkg::req_t req_q, req_d;
  logic           push;
  logic           take;

  assign push = valid_q && push_ready_i;
  // No request is taken while the back end sweeps the memory after reset.
  assign req_i.ready = !status_i.clearing && (!valid_q || push_ready_i);
  assign take = req_i.valid && req_i.ready;

  always_comb begin
    valid_d = valid_q;
    req_d   = req_q;
    if (push) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d     = 1'b1;
      req_d.addr  = req_i.address[bccs_pkg::MEM_AW-1:0];
      req_d.wdata = req_i.write_byte;
      case (req_i.kind)
        bccs_pkg::KIND_WRITE: req_d.op = bccs_pkg::OP_WRITE;
        bccs_pkg::KIND_READ:  req_d.op = bccs_pkg::OP_READ;
        bccs_pkg::KIND_EXEC:  req_d.op = bccs_pkg::OP_EXEC;
        default:              req_d.op = bccs_pkg::OP_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign push_valid_o = valid_q;
  assign push_req_o   = req_q;

endmodule

// ===== rtl/core/bccs_queue.sv =====
// Short request queue between the front end and the back end.
`timescale 1ns / 1ps
module bccs_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  bccs_pkg::req_t push_req_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output bccs_pkg::req_t pop_req_o,
  input  logic           pop_ready_i
);

  bccs_pkg::req_t                  entry_q [bccs_pkg::QDEPTH];
  logic [bccs_pkg::QPW-1:0]        wptr_q, wptr_d;
  logic [bccs_pkg::QPW-1:0]        rptr_q, rptr_d;
  logic [bccs_pkg::QCW-1:0]        cnt_q, cnt_d;
  logic                            push, pop;

  localparam logic [bccs_pkg::QPW-1:0] LAST = bccs_pkg::QPW'(bccs_pkg::QDEPTH - 1);
  localparam logic [bccs_pkg::QCW-1:0] FULL = bccs_pkg::QCW'(bccs_pkg::QDEPTH);

  assign push_ready_o = (cnt_q != FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_req_o    = entry_q[rptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == LAST) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= push_req_i;
    end
  end

endmodule

// ===== rtl/core/bccs_back.sv =====
// Back end: memory sweep, instruction sequencer, registers and response stage.
`timescale 1ns / 1ps
`include "byte_code_cpu_step_macros.svh"
module bccs_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   pop_valid_i,
  input  bccs_pkg::req_t         pop_req_i,
  output logic                   pop_ready_o,
  output bccs_pkg::back_status_t status_o,
  bccs_out_if.source             rsp_o
);

  localparam int unsigned AW = bccs_pkg::MEM_AW;

  bccs_pkg::state_e state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [15:0]      ip_q, ip_d;
  logic [15:0]      d1_q, d1_d;
  logic [15:0]      d2_q, d2_d;
  logic [15:0]      a1_q, a1_d;
  logic [15:0]      a2_q, a2_d;
  logic [7:0]       opc_q, opc_d;
  logic [7:0]       lo_q, lo_d;
  logic             zf_q, zf_d;
  logic             stop_q, stop_d;
  logic             bad_q, bad_d;
  logic             rsp_valid_q, rsp_valid_d;
  bccs_pkg::rsp_t   rsp_q;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;

  logic             pop;
  logic             finish;
  logic [7:0]       rbyte;
  logic [15:0]      word;

  bccs_ram #(
    .WIDTH (8),
    .DEPTH (bccs_pkg::MEM_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // A request is only taken when the response slot is free by the time it finishes.
  assign pop = (state_q == bccs_pkg::ST_IDLE) && pop_valid_i &&
               (!rsp_valid_q || rsp_o.ready);
  assign pop_ready_o = pop;
  assign status_o.clearing = (state_q == bccs_pkg::ST_CLEAR);
  assign word = {ram_rdata, lo_q};

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    ip_d      = ip_q;
    d1_d      = d1_q;
    d2_d      = d2_q;
    a1_d      = a1_q;
    a2_d      = a2_q;
    opc_d     = opc_q;
    lo_d      = lo_q;
    zf_d      = zf_q;
    stop_d    = stop_q;
    bad_d     = bad_q;
    ram_we    = 1'b0;
    ram_addr  = ip_q[AW-1:0];
    ram_wdata = d1_q[7:0];
    finish    = 1'b0;
    rbyte     = 8'h00;

    case (state_q)
      bccs_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = 8'h00;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = bccs_pkg::ST_IDLE;
        end
      end
      bccs_pkg::ST_IDLE: begin
        if (pop) begin
          case (pop_req_i.op)
            bccs_pkg::OP_WRITE: begin
              ram_we    = 1'b1;
              ram_addr  = pop_req_i.addr;
              ram_wdata = pop_req_i.wdata;
              finish    = 1'b1;
            end
            bccs_pkg::OP_READ: begin
              ram_addr = pop_req_i.addr;
              state_d  = bccs_pkg::ST_RD;
            end
            bccs_pkg::OP_EXEC: begin
              if (stop_q) begin
                finish = 1'b1;
              end else begin
                ip_d    = ip_q + 16'd1;
                state_d = bccs_pkg::ST_OPC;
              end
            end
            bccs_pkg::OP_NONE: finish = 1'b1;
            default:           finish = 1'b1;
          endcase
        end
      end
      bccs_pkg::ST_RD: begin
        rbyte  = ram_rdata;
        finish = 1'b1;
      end
      bccs_pkg::ST_OPC: begin
        opc_d  = ram_rdata;
        finish = 1'b1;
        case (ram_rdata)
          bccs_pkg::OPC_STOP: stop_d = 1'b1;
          bccs_pkg::OPC_LDB, bccs_pkg::OPC_LDW, bccs_pkg::OPC_JMP,
          bccs_pkg::OPC_JZ, bccs_pkg::OPC_JNZ: begin
            ip_d    = ip_q + 16'd1;
            finish  = 1'b0;
            state_d = bccs_pkg::ST_IMM_LO;
          end
          bccs_pkg::OPC_MVDA1: a1_d = d1_q;
          bccs_pkg::OPC_STA1: begin
            ram_we   = 1'b1;
            ram_addr = a1_q[AW-1:0];
          end
          bccs_pkg::OPC_MVA1D: d1_d = a1_q;
          bccs_pkg::OPC_MVD2D: d1_d = d2_q;
          bccs_pkg::OPC_MVDD2: d2_d = d1_q;
          bccs_pkg::OPC_MVDA2: a2_d = d1_q;
          bccs_pkg::OPC_INC:   d1_d = d1_q + 16'd1;
          bccs_pkg::OPC_DEC: begin
            d1_d = d1_q - 16'd1;
            zf_d = (d1_q == 16'd1);
          end
          bccs_pkg::OPC_STA2: begin
            ram_we   = 1'b1;
            ram_addr = a2_q[AW-1:0];
          end
          bccs_pkg::OPC_LDA1: begin
            ram_addr = a1_q[AW-1:0];
            finish   = 1'b0;
            state_d  = bccs_pkg::ST_DATA;
          end
          bccs_pkg::OPC_LDA2: begin
            ram_addr = a2_q[AW-1:0];
            finish   = 1'b0;
            state_d  = bccs_pkg::ST_DATA;
          end
          bccs_pkg::OPC_TST:   zf_d = (d1_q == 16'd0);
          bccs_pkg::OPC_TSTB:  zf_d = (d1_q[7:0] == 8'h00);
          bccs_pkg::OPC_MVA2D: d1_d = a2_q;
          bccs_pkg::OPC_NOP: ;
          default: begin
            stop_d = 1'b1;
            bad_d  = 1'b1;
          end
        endcase
      end
      bccs_pkg::ST_IMM_LO: begin
        if (opc_q == bccs_pkg::OPC_LDB) begin
          d1_d   = (d1_q & bccs_pkg::HI_MASK) | {8'h00, ram_rdata};
          finish = 1'b1;
        end else begin
          // First (low) immediate byte of a word operand.
          lo_d    = ram_rdata;
          ip_d    = ip_q + 16'd1;
          state_d = bccs_pkg::ST_IMM_HI;
        end
      end
      bccs_pkg::ST_IMM_HI: begin
        finish = 1'b1;
        case (opc_q)
          bccs_pkg::OPC_LDW: d1_d = word;
          bccs_pkg::OPC_JMP: ip_d = word;
          bccs_pkg::OPC_JZ:  ip_d = zf_q ? word : ip_q;
          bccs_pkg::OPC_JNZ: ip_d = zf_q ? ip_q : word;
          default: ;
        endcase
      end
      bccs_pkg::ST_DATA: begin
        d1_d   = (d1_q & bccs_pkg::HI_MASK) | {8'h00, ram_rdata};
        finish = 1'b1;
      end
      default: state_d = bccs_pkg::ST_IDLE;
    endcase

    if (finish) begin
      state_d = bccs_pkg::ST_IDLE;
    end

    rsp_valid_d = rsp_valid_q;
    if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (finish) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bccs_pkg::ST_CLEAR;
      clr_q       <= '0;
      ip_q        <= '0;
      d1_q        <= '0;
      d2_q        <= '0;
      a1_q        <= '0;
      a2_q        <= '0;
      opc_q       <= '0;
      zf_q        <= 1'b0;
      stop_q      <= 1'b0;
      bad_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      ip_q        <= ip_d;
      d1_q        <= d1_d;
      d2_q        <= d2_d;
      a1_q        <= a1_d;
      a2_q        <= a2_d;
      opc_q       <= opc_d;
      zf_q        <= zf_d;
      stop_q      <= stop_d;
      bad_q       <= bad_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    if (finish) begin
      rsp_q.read_byte     <= rbyte;
      rsp_q.instr_pointer <= ip_d;
      rsp_q.data_reg_one  <= d1_d;
      rsp_q.data_reg_two  <= d2_d;
      rsp_q.addr_reg_one  <= a1_d;
      rsp_q.addr_reg_two  <= a2_d;
      rsp_q.last_opcode   <= opc_d;
      rsp_q.zero_flag     <= zf_d;
      rsp_q.halted        <= stop_d;
      rsp_q.bad_opcode    <= bad_d;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.read_byte     = rsp_q.read_byte;
  assign rsp_o.instr_pointer = rsp_q.instr_pointer;
  assign rsp_o.data_reg_one  = rsp_q.data_reg_one;
  assign rsp_o.data_reg_two  = rsp_q.data_reg_two;
  assign rsp_o.addr_reg_one  = rsp_q.addr_reg_one;
  assign rsp_o.addr_reg_two  = rsp_q.addr_reg_two;
  assign rsp_o.last_opcode   = rsp_q.last_opcode;
  assign rsp_o.zero_flag     = rsp_q.zero_flag;
  assign rsp_o.halted        = rsp_q.halted;
  assign rsp_o.bad_opcode    = rsp_q.bad_opcode;

  `BCCS_ASSERT_NEVER(a_no_pop_in_clear, status_o.clearing && pop_ready_o,
    "request taken during memory sweep")
  `BCCS_ASSERT_NEVER(a_no_rsp_overwrite, finish && rsp_valid_q && !rsp_o.ready,
    "pending response overwritten")
  `BCCS_ASSERT(a_halt_ip_stable,
    (stop_q && pop && pop_req_i.op == bccs_pkg::OP_EXEC) |=> $stable(ip_q),
    "instruction pointer moved while halted")
  `BCCS_ASSERT_NEVER(a_bad_without_stop, bad_q && !stop_q,
    "invalid-opcode flag set without halt")

endmodule

// ===== rtl/core/byte_code_cpu_step.sv =====
// Top level of the 16-bit byte-code core with its byte-wide local memory.
//
// Requests arrive on req_i (valid/ready): kind selects a memory byte write,
// a memory byte read or the execution of one instruction; kind 3 does
// nothing. Every request yields exactly one response on rsp_o (valid/ready)
// that carries the read byte and the register and flag values after it.
// A request passes a front register and a two-entry queue before the back
// end, which owns the single-port memory. In the back end a write finishes
// in ST_IDLE when taken, a read passes through ST_RD, and an instruction
// reads its opcode in ST_OPC, then up to two immediate bytes in ST_IMM_LO
// and ST_IMM_HI or one data byte in ST_DATA, one memory access per cycle.
// Kind 3 and an execute on a halted core finish in ST_IDLE when taken.
// With rsp_o ready the back end takes the next request in the cycle after
// one finishes. After reset the back end clears all MEM_BYTES memory bytes,
// one per cycle, and req_i.ready stays low until the sweep is done. When
// rsp_o is stalled the back end holds its result and takes nothing from the
// queue; the front accepts requests until its register and queue are full.
`timescale 1ns / 1ps
module byte_code_cpu_step (
  input  logic       clk_i,
  input  logic       rst_ni,
  bccs_in_if.sink    req_i,
  bccs_out_if.source rsp_o
);

  bccs_pkg::back_status_t status;
  logic                   push_valid, push_ready;
  bccs_pkg::req_t         push_req;
  logic                   pop_valid, pop_ready;
  bccs_pkg::req_t         pop_req;

  bccs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .status_i     (status),
    .push_valid_o (push_valid),
    .push_req_o   (push_req),
    .push_ready_i (push_ready)
  );

  bccs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_req_i   (push_req),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_req_o    (pop_req),
    .pop_ready_i  (pop_ready)
  );

  bccs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_req_i   (pop_req),
    .pop_ready_o (pop_ready),
    .status_o    (status),
    .rsp_o       (rsp_o)
  );

endmodule
